>>> hw/rtl/pcs_pkg.sv
// ----------------------------------------------------------------------------
// pcs_pkg
// Shared types, codes and the sample conversion for the precharge sequencer.
// ----------------------------------------------------------------------------
package pcs_pkg;

	localparam int MvW      = 12;
	localparam int PollW    = 16;
	localparam int StableW  = 8;
	localparam int CfgIdxW  = 3;
	localparam int CfgDataW = 16;

	localparam logic [MvW-1:0]     FullScaleMv = 12'd3300;
	localparam logic [MvW:0]       AdcMax      = 13'd4095;
	localparam logic [PollW-1:0]   PollMax     = 16'hFFFF;
	localparam logic [StableW-1:0] StableMax   = 8'hFF;

	typedef enum logic [1:0] {
		CMD_POLL      = 2'd0,
		CMD_START     = 2'd1,
		CMD_PRECHARGE = 2'd2,
		CMD_CONTACTOR = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		PH_IDLE   = 3'd0,
		PH_ADC    = 3'd1,
		PH_FIXED  = 3'd2,
		PH_SETTLE = 3'd3,
		PH_CLOSED = 3'd4
	} phase_t;

	typedef enum logic [1:0] {
		OUT_NONE     = 2'd0,
		OUT_COMPLETE = 2'd1,
		OUT_ADC_FAIL = 2'd2,
		OUT_TIMEOUT  = 2'd3
	} outcome_t;

	typedef enum logic [CfgIdxW-1:0] {
		REG_USE_ADC_GATE  = 3'd0,
		REG_REQUIRE_ADC   = 3'd1,
		REG_THRESHOLD     = 3'd2,
		REG_MIN_DWELL     = 3'd3,
		REG_TIMEOUT       = 3'd4,
		REG_STABLE_REQ    = 3'd5,
		REG_FIXED_DELAY   = 3'd6,
		REG_SETTLE        = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic               use_adc_gate;
		logic               require_adc;
		logic [MvW-1:0]     threshold_sensor_mv;
		logic [PollW-1:0]   min_dwell_polls;
		logic [PollW-1:0]   timeout_polls;
		logic [StableW-1:0] stable_required;
		logic [PollW-1:0]   fixed_delay_polls;
		logic [PollW-1:0]   settle_polls;
	} cfg_t;

	typedef struct packed {
		cmd_t           cmd;
		logic           enable;
		logic           adc_valid;
		logic [MvW-1:0] adc_raw;
	} item_t;

	typedef struct packed {
		phase_t             phase;
		logic               precharge;
		logic               contactor;
		logic [PollW-1:0]   elapsed;
		logic [StableW-1:0] stable;
		outcome_t           outcome;
		logic [MvW-1:0]     latest_mv;
	} seq_state_t;

	// raw * 3300 / 4095, truncated. With q0 = x >> 12 the remainder against
	// 4095 is (x mod 4096) + q0, which stays below twice 4095.
	function automatic logic [MvW-1:0] to_sensor_mv(input logic [MvW-1:0] raw);
		logic [2*MvW-1:0] prod;
		logic [MvW-1:0]   q0;
		logic [MvW:0]     rem;
		prod = {{MvW{1'b0}}, raw} * {{MvW{1'b0}}, FullScaleMv};
		q0   = prod[2*MvW-1:MvW];
		rem  = {1'b0, prod[MvW-1:0]} + {1'b0, q0};
		return q0 + {{(MvW-1){1'b0}}, (rem >= AdcMax)};
	endfunction

	function automatic logic [PollW-1:0] sat_inc(input logic [PollW-1:0] v);
		return (v == PollMax) ? v : v + 16'd1;
	endfunction

endpackage

>>> hw/rtl/pcs_step.sv
// ----------------------------------------------------------------------------
// pcs_step
// Next-state logic of the sequencer for one accepted item.
// ----------------------------------------------------------------------------
module pcs_step (
	input  pcs_pkg::cfg_t       cfg,
	input  pcs_pkg::item_t      item,
	input  pcs_pkg::seq_state_t cur,
	output pcs_pkg::seq_state_t nxt
);
	import pcs_pkg::*;

	logic [MvW-1:0]     mv_new;
	logic [StableW-1:0] need;
	logic [StableW-1:0] stable_inc;

	assign mv_new     = to_sensor_mv(item.adc_raw);
	assign need       = (cfg.stable_required == '0) ? 8'd1 : cfg.stable_required;
	assign stable_inc = (cur.stable == StableMax) ? cur.stable : cur.stable + 8'd1;

	always_comb begin
		logic             do_fixed;
		logic             do_done;
		logic             do_finish;
		logic [PollW-1:0] e_inc;
		nxt       = cur;
		do_fixed  = 1'b0;
		do_done   = 1'b0;
		do_finish = 1'b0;
		e_inc     = sat_inc(cur.elapsed);
		case (item.cmd)
			CMD_START: begin
				nxt.elapsed   = '0;
				nxt.stable    = '0;
				nxt.outcome   = OUT_NONE;
				nxt.contactor = 1'b0;
				nxt.precharge = 1'b1;
				if (cfg.use_adc_gate && item.adc_valid) begin
					nxt.phase = PH_ADC;
				end else if (cfg.use_adc_gate && cfg.require_adc) begin
					nxt.precharge = 1'b0;
					nxt.phase     = PH_IDLE;
					nxt.outcome   = OUT_ADC_FAIL;
				end else begin
					do_fixed = 1'b1;
				end
			end
			CMD_PRECHARGE: begin
				nxt.precharge = item.enable;
			end
			CMD_CONTACTOR: begin
				nxt.contactor = item.enable;
			end
			default: begin
				if (item.adc_valid) begin
					nxt.latest_mv = mv_new;
				end
				case (cur.phase)
					PH_ADC: begin
						if (!item.adc_valid) begin
							nxt.precharge = 1'b0;
							nxt.contactor = 1'b0;
							nxt.phase     = PH_IDLE;
							nxt.outcome   = OUT_ADC_FAIL;
						end else begin
							if (cur.elapsed >= cfg.min_dwell_polls) begin
								if (mv_new >= cfg.threshold_sensor_mv) begin
									nxt.stable = stable_inc;
									do_done    = (stable_inc >= need);
								end else begin
									nxt.stable = '0;
								end
							end
							if (!do_done) begin
								if (cur.elapsed >= cfg.timeout_polls) begin
									nxt.precharge = 1'b0;
									nxt.contactor = 1'b0;
									nxt.phase     = PH_IDLE;
									nxt.outcome   = OUT_TIMEOUT;
								end else begin
									nxt.elapsed = e_inc;
								end
							end
						end
					end
					PH_FIXED: begin
						nxt.elapsed = e_inc;
						do_done     = (e_inc >= cfg.fixed_delay_polls);
					end
					PH_SETTLE: begin
						nxt.elapsed = e_inc;
						do_finish   = (e_inc >= cfg.settle_polls);
					end
					default: begin
					end
				endcase
			end
		endcase
		if (do_fixed) begin
			nxt.phase = PH_FIXED;
			do_done   = (cfg.fixed_delay_polls == '0);
		end
		// precharge reached: close the contactor and start settling
		if (do_done) begin
			nxt.contactor = 1'b1;
			nxt.elapsed   = '0;
			nxt.phase     = PH_SETTLE;
			do_finish     = (cfg.settle_polls == '0);
		end
		if (do_finish) begin
			nxt.precharge = 1'b0;
			nxt.phase     = PH_CLOSED;
			nxt.outcome   = OUT_COMPLETE;
		end
	end

endmodule

>>> hw/rtl/precharge_contactor_sequencer.sv
// ----------------------------------------------------------------------------
// precharge_contactor_sequencer
// DC-bus precharge and main contactor sequencer, one result per item.
// ----------------------------------------------------------------------------
// Takes one item per clock while in_stall is low and returns one result per
// item: the item is captured in an input register, then the next-state logic
// (sample conversion, compare and count) updates the sequencer state once the
// result slot is free. The state registers are the result register, so a
// result shows the relay drives, phase, outcome and counters after its item.
// The input side keeps taking items while a result waits, up to one item held
// in the input register. The user must write configuration registers through
// the plain write port while no item is in flight; the block does not check.
module precharge_contactor_sequencer (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [1:0]                      cmd,
	input  logic                            enable,
	input  logic                            adc_valid,
	input  logic [11:0]                     adc_raw,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic                            precharge_on,
	output logic                            contactor_on,
	output logic [2:0]                      phase,
	output logic [1:0]                      outcome,
	output logic [11:0]                     sensor_mv,
	output logic [15:0]                     elapsed_polls,
	output logic [7:0]                      stable_count,
	input  logic                            cfg_we,
	input  logic [pcs_pkg::CfgIdxW-1:0]     cfg_index,
	input  logic [pcs_pkg::CfgDataW-1:0]    cfg_data
);
	import pcs_pkg::*;

	cfg_t       cfg_q;
	item_t      item_s1;
	logic       valid_s1;
	seq_state_t state_q;
	seq_state_t state_nxt;
	logic       out_valid_q;
	logic       advance;
	logic       in_take;

	// move the held item into the state when the result slot is free
	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign in_take  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.use_adc_gate        <= 1'b1;
			cfg_q.require_adc         <= 1'b1;
			cfg_q.threshold_sensor_mv <= 12'd3300;
			cfg_q.min_dwell_polls     <= 16'd10;
			cfg_q.timeout_polls       <= 16'd400;
			cfg_q.stable_required     <= 8'd3;
			cfg_q.fixed_delay_polls   <= 16'd400;
			cfg_q.settle_polls        <= 16'd5;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_USE_ADC_GATE: cfg_q.use_adc_gate        <= cfg_data[0];
				REG_REQUIRE_ADC:  cfg_q.require_adc         <= cfg_data[0];
				REG_THRESHOLD:    cfg_q.threshold_sensor_mv <= cfg_data[MvW-1:0];
				REG_MIN_DWELL:    cfg_q.min_dwell_polls     <= cfg_data;
				REG_TIMEOUT:      cfg_q.timeout_polls       <= cfg_data;
				REG_STABLE_REQ:   cfg_q.stable_required     <= cfg_data[StableW-1:0];
				REG_FIXED_DELAY:  cfg_q.fixed_delay_polls   <= cfg_data;
				REG_SETTLE:       cfg_q.settle_polls        <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			item_s1.cmd       <= cmd_t'(cmd);
			item_s1.enable    <= enable;
			item_s1.adc_valid <= adc_valid;
			item_s1.adc_raw   <= adc_raw;
		end
	end

	pcs_step u_step (
		.cfg  (cfg_q),
		.item (item_s1),
		.cur  (state_q),
		.nxt  (state_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.phase     <= PH_IDLE;
			state_q.precharge <= 1'b0;
			state_q.contactor <= 1'b0;
			state_q.elapsed   <= '0;
			state_q.stable    <= '0;
			state_q.outcome   <= OUT_NONE;
			state_q.latest_mv <= '0;
			out_valid_q       <= 1'b0;
		end else begin
			if (advance) begin
				state_q     <= state_nxt;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign precharge_on  = state_q.precharge;
	assign contactor_on  = state_q.contactor;
	assign phase         = state_q.phase;
	assign outcome       = state_q.outcome;
	assign sensor_mv     = state_q.latest_mv;
	assign elapsed_polls = state_q.elapsed;
	assign stable_count  = state_q.stable;

endmodule

>>> tb/sv/precharge_contactor_sequencer_test.sv
// ----------------------------------------------------------------------------
// precharge_contactor_sequencer_test
// Drives start, relay and poll items into the precharge sequencer under random
// sender bursts and receiver stalls. Each accepted item advances a local model
// of the sequence, and every result is checked field by field against it.
// ----------------------------------------------------------------------------
module precharge_contactor_sequencer_test;
	import pcs_pkg::*;

	typedef struct {
		logic               precharge;
		logic               contactor;
		phase_t             ph;
		outcome_t           oc;
		logic [MvW-1:0]     mv;
		logic [PollW-1:0]   el;
		logic [StableW-1:0] st;
	} status_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_stall;
	logic [1:0]          cmd = 2'd0;
	logic                enable = 1'b0;
	logic                adc_valid = 1'b0;
	logic [11:0]         adc_raw = 12'd0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic                precharge_on;
	logic                contactor_on;
	logic [2:0]          phase;
	logic [1:0]          outcome;
	logic [11:0]         sensor_mv;
	logic [15:0]         elapsed_polls;
	logic [7:0]          stable_count;
	logic                cfg_we = 1'b0;
	logic [CfgIdxW-1:0]  cfg_index = '0;
	logic [CfgDataW-1:0] cfg_data = '0;

	precharge_contactor_sequencer u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.cmd           (cmd),
		.enable        (enable),
		.adc_valid     (adc_valid),
		.adc_raw       (adc_raw),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.precharge_on  (precharge_on),
		.contactor_on  (contactor_on),
		.phase         (phase),
		.outcome       (outcome),
		.sensor_mv     (sensor_mv),
		.elapsed_polls (elapsed_polls),
		.stable_count  (stable_count),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Model configuration, starting from the reset values
	logic               cfg_gate   = 1'b1;
	logic               cfg_req    = 1'b1;
	logic [MvW-1:0]     cfg_thr    = 12'd3300;
	logic [PollW-1:0]   cfg_dwell  = 16'd10;
	logic [PollW-1:0]   cfg_tmo    = 16'd400;
	logic [StableW-1:0] cfg_stable = 8'd3;
	logic [PollW-1:0]   cfg_fixed  = 16'd400;
	logic [PollW-1:0]   cfg_settle = 16'd5;

	status_t seq = '{1'b0, 1'b0, PH_IDLE, OUT_NONE, '0, '0, '0};

	item_t   pending_items[$];
	status_t expected_status[$];
	status_t seen_exp;
	int      mismatches = 0;
	int      queued_count = 0;

	// Open both relays and end the sequence
	task automatic trip(input outcome_t code);
		seq.precharge = 1'b0;
		seq.contactor = 1'b0;
		seq.ph = PH_IDLE;
		seq.oc = code;
	endtask

	task automatic close_out();
		seq.precharge = 1'b0;
		seq.ph = PH_CLOSED;
		seq.oc = OUT_COMPLETE;
	endtask

	task automatic bus_charged();
		seq.contactor = 1'b1;
		seq.el = '0;
		if (cfg_settle == 0)
			close_out();
		else
			seq.ph = PH_SETTLE;
	endtask

	task automatic begin_fixed();
		seq.ph = PH_FIXED;
		if (cfg_fixed == 0)
			bus_charged();
	endtask

	task automatic advance_sequencer(input item_t it);
		logic [StableW-1:0] need;
		logic               done;
		need = (cfg_stable == 0) ? 8'd1 : cfg_stable;
		done = 1'b0;
		case (it.cmd)
			CMD_START: begin
				seq.el = '0;
				seq.st = '0;
				seq.oc = OUT_NONE;
				seq.contactor = 1'b0;
				seq.precharge = 1'b1;
				if (!cfg_gate)
					begin_fixed();
				else if (it.adc_valid)
					seq.ph = PH_ADC;
				else if (cfg_req)
					trip(OUT_ADC_FAIL);
				else
					begin_fixed();
			end
			CMD_PRECHARGE: seq.precharge = it.enable;
			CMD_CONTACTOR: seq.contactor = it.enable;
			default: begin
				if (it.adc_valid)
					seq.mv = MvW'((int'(it.adc_raw) * 3300) / 4095);
				case (seq.ph)
					PH_ADC: begin
						if (!it.adc_valid) begin
							trip(OUT_ADC_FAIL);
							done = 1'b1;
						end else if (seq.el >= cfg_dwell) begin
							if (seq.mv >= cfg_thr) begin
								if (seq.st != StableMax)
									seq.st++;
								if (seq.st >= need) begin
									bus_charged();
									done = 1'b1;
								end
							end else begin
								seq.st = '0;
							end
						end
						if (!done) begin
							if (seq.el >= cfg_tmo)
								trip(OUT_TIMEOUT);
							else if (seq.el != PollMax)
								seq.el++;
						end
					end
					PH_FIXED: begin
						if (seq.el != PollMax)
							seq.el++;
						if (seq.el >= cfg_fixed)
							bus_charged();
					end
					PH_SETTLE: begin
						if (seq.el != PollMax)
							seq.el++;
						if (seq.el >= cfg_settle)
							close_out();
					end
					default: ;
				endcase
			end
		endcase
		expected_status.push_back(seq);
	endtask

	// Sender: bursts of random length separated by random gaps
	item_t cur_item;
	int    burst_left = 0;
	int    gap_left = 0;

	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall)
				advance_sequencer(cur_item);
			if (!in_valid || !in_stall) begin
				if (gap_left > 0 || pending_items.size() == 0) begin
					if (gap_left > 0)
						gap_left--;
					in_valid <= 1'b0;
				end else begin
					cur_item = pending_items.pop_front();
					cmd <= cur_item.cmd;
					enable <= cur_item.enable;
					adc_valid <= cur_item.adc_valid;
					adc_raw <= cur_item.adc_raw;
					in_valid <= 1'b1;
					burst_left--;
					if (burst_left <= 0) begin
						burst_left = ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(1, 16);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
					end
				end
			end
		end
	end

	// Receiver: stall mode held for a random stretch of cycles
	int stall_mode = 0;
	int stall_left = 0;

	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_mode = $urandom_range(0, 2);
			stall_left = $urandom_range(8, 48);
		end else begin
			stall_left--;
		end
		case (stall_mode)
			0: out_stall <= 1'b0;
			1: out_stall <= ($urandom_range(0, 3) == 0);
			default: out_stall <= ($urandom_range(0, 3) != 0);
		endcase
	end

	task automatic check_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			mismatches++;
			if (mismatches <= 10)
				$display("%0t: %s mismatch: expected %0d, got %0d", $realtime, name, want, got);
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (expected_status.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: result with no item pending", $realtime);
			end else begin
				seen_exp = expected_status.pop_front();
				check_field("precharge_on", 32'(seen_exp.precharge), 32'(precharge_on));
				check_field("contactor_on", 32'(seen_exp.contactor), 32'(contactor_on));
				check_field("phase", 32'(seen_exp.ph), 32'(phase));
				check_field("outcome", 32'(seen_exp.oc), 32'(outcome));
				check_field("sensor_mv", 32'(seen_exp.mv), 32'(sensor_mv));
				check_field("elapsed_polls", 32'(seen_exp.el), 32'(elapsed_polls));
				check_field("stable_count", 32'(seen_exp.st), 32'(stable_count));
			end
		end
	end

	task automatic queue_item(input cmd_t c, input logic en, input logic v,
			input logic [11:0] raw);
		item_t it;
		it.cmd = c;
		it.enable = en;
		it.adc_valid = v;
		it.adc_raw = raw;
		pending_items.push_back(it);
		queued_count++;
	endtask

	// Wait until every item has gone through and its result has come back
	task automatic drain();
		while (pending_items.size() != 0 || in_valid || expected_status.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [15:0] value);
		logic [15:0] junk;
		logic [15:0] data;
		junk = $urandom_range(0, 1) ? 16'($urandom) : 16'h0;
		data = value;
		case (idx)
			REG_USE_ADC_GATE: begin
				data = {junk[15:1], value[0]};
				cfg_gate = value[0];
			end
			REG_REQUIRE_ADC: begin
				data = {junk[15:1], value[0]};
				cfg_req = value[0];
			end
			REG_THRESHOLD: begin
				data = {junk[15:12], value[11:0]};
				cfg_thr = value[11:0];
			end
			REG_MIN_DWELL: cfg_dwell = value;
			REG_TIMEOUT: cfg_tmo = value;
			REG_STABLE_REQ: begin
				data = {junk[15:8], value[7:0]};
				cfg_stable = value[7:0];
			end
			REG_FIXED_DELAY: cfg_fixed = value;
			default: cfg_settle = value;
		endcase
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_config(input logic gate, input logic req, input logic [11:0] thr,
			input logic [15:0] dwell, input logic [15:0] tmo, input logic [7:0] stab,
			input logic [15:0] fixed_dly, input logic [15:0] settle);
		drain();
		write_reg(REG_USE_ADC_GATE, 16'(gate));
		write_reg(REG_REQUIRE_ADC, 16'(req));
		write_reg(REG_THRESHOLD, 16'(thr));
		write_reg(REG_MIN_DWELL, dwell);
		write_reg(REG_TIMEOUT, tmo);
		write_reg(REG_STABLE_REQ, 16'(stab));
		write_reg(REG_FIXED_DELAY, fixed_dly);
		write_reg(REG_SETTLE, settle);
	endtask

	// Lowest raw count whose converted value reaches the threshold
	function automatic logic [11:0] min_raw_for(input logic [11:0] thr);
		int unsigned r;
		r = (int'(thr) * 4095 + 3299) / 3300;
		return (r > 4095) ? 12'd4095 : 12'(r);
	endfunction

	// Mostly a start followed by polls that climb over the threshold, with
	// dips, bad samples, relay commands and restarts mixed in
	task automatic queue_sequence();
		logic [11:0] floor_raw;
		int          r;
		floor_raw = min_raw_for(cfg_thr);
		if ($urandom_range(0, 9) == 0) begin
			repeat ($urandom_range(1, 5))
				queue_item(cmd_t'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
					1'($urandom_range(0, 1)), 12'($urandom));
		end else begin
			queue_item(CMD_START, 1'($urandom_range(0, 1)), $urandom_range(0, 9) != 0,
				12'($urandom));
			repeat ($urandom_range(3, 30)) begin
				r = $urandom_range(0, 39);
				if (r == 0)
					queue_item(CMD_POLL, 1'($urandom_range(0, 1)), 1'b0, 12'($urandom));
				else if (r == 1)
					queue_item(CMD_START, 1'($urandom_range(0, 1)), 1'b1, 12'($urandom));
				else if (r < 4)
					queue_item(cmd_t'($urandom_range(2, 3)), 1'($urandom_range(0, 1)),
						1'($urandom_range(0, 1)), 12'($urandom));
				else if (r < 12)
					queue_item(CMD_POLL, 1'($urandom_range(0, 1)), 1'b1, 12'($urandom));
				else
					queue_item(CMD_POLL, 1'($urandom_range(0, 1)), 1'b1,
						12'($urandom_range(floor_raw, 4095)));
			end
		end
	endtask

	initial begin
		int phase_start;
		int random_start;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Reset configuration: sampling while idle, refused start, relays,
		// bad sample, dwell, run and dip, restart while busy
		queue_item(CMD_POLL, 1'b0, 1'b1, 12'd0);
		queue_item(CMD_POLL, 1'b1, 1'b1, 12'd4095);
		queue_item(CMD_POLL, 1'b0, 1'b0, 12'd0);
		queue_item(CMD_START, 1'b1, 1'b0, 12'd4095);
		queue_item(CMD_PRECHARGE, 1'b1, 1'b0, 12'd0);
		queue_item(CMD_CONTACTOR, 1'b1, 1'b1, 12'd0);
		queue_item(CMD_PRECHARGE, 1'b0, 1'b1, 12'd4095);
		queue_item(CMD_CONTACTOR, 1'b0, 1'b0, 12'd4095);
		queue_item(CMD_START, 1'b0, 1'b1, 12'd0);
		queue_item(CMD_POLL, 1'b1, 1'b0, 12'd4095);
		queue_item(CMD_START, 1'b0, 1'b1, 12'd2048);
		repeat (10) queue_item(CMD_POLL, 1'b0, 1'b1, 12'd4095);
		queue_item(CMD_POLL, 1'b0, 1'b1, 12'd4095);
		queue_item(CMD_POLL, 1'b1, 1'b1, 12'd4095);
		queue_item(CMD_POLL, 1'b0, 1'b1, 12'd0);
		queue_item(CMD_START, 1'b1, 1'b1, 12'd0);

		// No gate, zero delays: success at start, closed at once
		set_config(1'b0, 1'b0, 12'd4095, 16'd0, 16'd0, 8'd0, 16'd0, 16'd0);
		queue_item(CMD_START, 1'b0, 1'b1, 12'd100);
		queue_item(CMD_POLL, 1'b1, 1'b1, 12'd1);
		queue_item(CMD_PRECHARGE, 1'b1, 1'b0, 12'd0);

		// Gate without ADC falls back to the fixed delay; zero timeout trips
		set_config(1'b1, 1'b0, 12'd4095, 16'd0, 16'd0, 8'd0, 16'd0, 16'd0);
		queue_item(CMD_START, 1'b0, 1'b0, 12'd0);
		queue_item(CMD_START, 1'b0, 1'b1, 12'd0);
		queue_item(CMD_POLL, 1'b0, 1'b1, 12'd4095);

		// Longest run: every sample counts until the stable count saturates
		set_config(1'b1, 1'b1, 12'd0, 16'd0, 16'd300, 8'd255, 16'd65535, 16'd65535);
		queue_item(CMD_START, 1'b1, 1'b1, 12'd0);
		repeat (260) queue_item(CMD_POLL, 1'($urandom_range(0, 1)), 1'b1, 12'($urandom));

		set_config(1'b1, 1'b1, 12'd3300, 16'd65535, 16'd65535, 8'd255, 16'd65535,
			16'd65535);
		repeat (3) queue_sequence();
		set_config(1'b0, 1'b1, 12'd3300, 16'd65535, 16'd65535, 8'd1, 16'd65535, 16'd0);
		repeat (3) queue_sequence();

		random_start = queued_count;
		while (queued_count - random_start < 120) begin
			set_config($urandom_range(0, 3) != 0, 1'($urandom_range(0, 1)),
				12'($urandom_range(0, 3300)), 16'($urandom_range(0, 6)),
				16'($urandom_range(0, 36)), 8'($urandom_range(0, 6)),
				16'($urandom_range(0, 8)), 16'($urandom_range(0, 8)));
			if (cfg_tmo < cfg_dwell)
				write_reg(REG_TIMEOUT, cfg_dwell + 16'($urandom_range(0, 30)));
			phase_start = queued_count;
			while (queued_count - phase_start < 25)
				queue_sequence();
		end

		drain();
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("precharge_contactor_sequencer_test: PASS");
		else
			$display("precharge_contactor_sequencer_test: FAIL");
		$finish;
	end

	initial begin
		#4000000;
		$display("precharge_contactor_sequencer_test: FAIL");
		$finish;
	end

endmodule

>>> sim.f
hw/rtl/pcs_pkg.sv
hw/rtl/pcs_step.sv
hw/rtl/precharge_contactor_sequencer.sv
tb/sv/precharge_contactor_sequencer_test.sv
